// File: sv/bctd_pkg.sv
// ----------------------------------------------------------------------------
// bctd_pkg
// Shared types and constants of the disk-block cache tag directory.
// ----------------------------------------------------------------------------
package bctd_pkg;

	// default geometry
	localparam int ENTRIES_DEF     = 128;
	localparam int BLOCK_SHIFT_DEF = 15;

	// field widths
	localparam int OWNER_W   = 16;
	localparam int BLOCK_W   = 17;
	localparam int WORD_W    = OWNER_W + BLOCK_W;
	localparam int TICK_W    = 8;
	localparam int IDX_OUT_W = 7;
	localparam int POS_W     = 32;
	localparam int LEN_W     = 20;
	localparam int TIMER_W   = 20;
	localparam int TIMER_LSB = 5;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_ENTRIES_IN_USE = 1'b0;

	// owner id that marks a free entry
	localparam logic [OWNER_W-1:0] FREE_ID = 16'hFFFF;

	typedef enum logic [1:0] {
		CMD_LOOKUP    = 2'd0,
		CMD_ALLOCATE  = 2'd1,
		CMD_INV_RANGE = 2'd2,
		CMD_INV_ALL   = 2'd3
	} cmd_t;

endpackage

// File: sv/bctd_ram.sv
// ----------------------------------------------------------------------------
// bctd_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bctd_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/bctd_mod.sv
// ----------------------------------------------------------------------------
// bctd_mod
// Restoring remainder unit: one dividend bit per cycle over the TICK_W-bit dividend.
// ----------------------------------------------------------------------------
module bctd_mod
	import bctd_pkg::*;
#(
	parameter int NW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TICK_W-1:0] dividend,
	input  logic [NW-1:0]     divisor,
	output logic              busy,
	output logic [NW-1:0]     remainder
);

	localparam int SW = $clog2(TICK_W);

	logic [TICK_W-1:0] div_q;
	logic [NW-1:0]     rem_q;
	logic [SW-1:0]     step_q;
	logic              busy_q;
	logic [NW:0]       trial;

	// shift in the next dividend bit
	assign trial = {rem_q, div_q[TICK_W-1]};

	// advance one bit per cycle while busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + SW'(1);
			if (step_q == SW'(TICK_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// payload of the iteration
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			div_q <= div_q << 1;
			if (trial >= {1'b0, divisor}) begin
				rem_q <= NW'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[NW-1:0];
			end
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

endmodule

// File: sv/block_cache_tag_directory.sv
// ----------------------------------------------------------------------------
// block_cache_tag_directory
// Tag directory of a fully associative disk-block cache with pseudo-random
// replacement. Tags sit in one RAM that is scanned one entry per cycle.
//
// Channel    Direction  Signals                                   Transfer
// command    in         start, busy, command..timer_usec          start && !busy
// result     out        done, hit..allocate_done                  done, one cycle
// config     in/out     psel, penable, pwrite, paddr, pwdata, ...  APB write
//
// Flow: a lookup, allocate or invalidate range scans the n active entries
// through the RAM read port in PREP, SCAN and FINISH (an allocate also waits
// in FINISH on the 8-step remainder unit). Invalidate all, a disabled cache
// or an invalid range end in PREP. busy is high from acceptance up to the
// done cycle; a new command can be taken in the done cycle.
// Reset clears the per-entry valid flops at once, so no clearing pass runs.
// The receiver cannot stall: done lasts exactly one cycle.
// ----------------------------------------------------------------------------
module block_cache_tag_directory
	import bctd_pkg::*;
#(
	parameter int ENTRIES     = ENTRIES_DEF,
	parameter int BLOCK_SHIFT = BLOCK_SHIFT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command channel
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            command,
	input  logic [OWNER_W-1:0]    disk_id,
	input  logic [POS_W-1:0]      byte_pos,
	input  logic [LEN_W-1:0]      byte_len,
	input  logic [BLOCK_W-1:0]    block_number,
	input  logic [TIMER_W-1:0]    timer_usec,
	// result channel
	output logic                  done,
	output logic                  hit,
	output logic [1:0]            span_blocks,
	output logic [IDX_OUT_W-1:0]  first_entry,
	output logic [IDX_OUT_W-1:0]  second_entry,
	output logic [IDX_OUT_W-1:0]  allocated_entry,
	output logic                  allocate_done,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int BW = POS_W + 1 - BLOCK_SHIFT;
	localparam int XW = (BW > BLOCK_W) ? BW : BLOCK_W;
	localparam int LW = LEN_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_PREP   = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;

	// captured command
	cmd_t               cmd_q;
	logic [OWNER_W-1:0] id_q;
	logic [POS_W-1:0]   pos_q;
	logic [LEN_W-1:0]   len_q;
	logic [BLOCK_W-1:0] blk_q;
	logic [TIMER_W-1:0] tmr_q;

	// block span
	logic [XW-1:0] bs_q;
	logic [XW-1:0] be_q;
	logic          span2_q;

	// scan pipeline
	logic [CW-1:0] cnt_q;
	logic          rd_s1;
	logic [IW-1:0] idx_s1;
	logic          last_s1;

	// scan findings
	logic          found_a_q;
	logic [IW-1:0] ent_a_q;
	logic          found_b_q;
	logic [IW-1:0] ent_b_q;
	logic          found_free_q;
	logic [IW-1:0] free_idx_q;

	logic [ENTRIES-1:0] valid_q;
	logic [TICK_W-1:0]  tick_q;
	logic [7:0]         eiu_q;

	// result registers
	logic                 done_q;
	logic                 hit_q;
	logic [1:0]           span_q;
	logic [IDX_OUT_W-1:0] first_q;
	logic [IDX_OUT_W-1:0] second_q;
	logic [IDX_OUT_W-1:0] alloc_ent_q;
	logic                 alloc_done_q;

	// combinational
	logic [8:0]         n_full;
	logic [CW-1:0]      n;
	logic [POS_W:0]     end_pos;
	logic [POS_W:0]     bs_full;
	logic [POS_W:0]     be_full;
	logic [XW-1:0]      bs_c;
	logic [XW-1:0]      be_c;
	logic               len_ok;
	logic               span2_c;
	logic [TICK_W-1:0]  tick_next;
	logic [TICK_W-1:0]  mod_dividend;
	logic               mod_start;
	logic               mod_busy;
	logic [CW-1:0]      mod_rem;
	logic               issue;
	logic [WORD_W-1:0]  rd_word;
	logic [OWNER_W-1:0] rd_owner;
	logic [XW-1:0]      rd_blk;
	logic               rd_valid;
	logic               owner_hit;
	logic               match_a;
	logic               match_b;
	logic               match_inv;
	logic               is_free;
	logic [IW-1:0]      alloc_idx;
	logic               ram_we;
	logic               cfg_write;

	// entry index to the 7-bit result field
	function automatic logic [IDX_OUT_W-1:0] to_out(input logic [IW-1:0] idx);
		logic [IW+IDX_OUT_W-1:0] w;
		w = {{IDX_OUT_W{1'b0}}, idx};
		return w[IDX_OUT_W-1:0];
	endfunction

	// active entry count, clamped to the directory size
	assign n_full = ({1'b0, eiu_q} > 9'(ENTRIES)) ? 9'(ENTRIES) : {1'b0, eiu_q};
	assign n      = n_full[CW-1:0];

	// span of the captured range
	assign end_pos = {1'b0, pos_q} + (POS_W + 1)'(len_q) - (POS_W + 1)'(1);
	assign bs_full = {1'b0, pos_q} >> BLOCK_SHIFT;
	assign be_full = end_pos >> BLOCK_SHIFT;
	assign bs_c    = XW'(bs_full);
	assign be_c    = XW'(be_full);
	assign len_ok  = (len_q != '0) && ({1'b0, len_q} <= (LW'(1) << BLOCK_SHIFT));
	assign span2_c = (be_c != bs_c);

	// replacement seed
	assign tick_next    = tick_q + TICK_W'(1);
	assign mod_dividend = tick_next + tmr_q[TIMER_LSB +: TICK_W];
	assign mod_start    = (state_q == ST_PREP) && (cmd_q == CMD_ALLOCATE) && (n != '0);

	bctd_mod #(
		.NW (CW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (mod_dividend),
		.divisor   (n),
		.busy      (mod_busy),
		.remainder (mod_rem)
	);

	// tag RAM: owner over block
	assign issue     = (state_q == ST_SCAN) && (cnt_q < n);
	assign alloc_idx = found_free_q ? free_idx_q : mod_rem[IW-1:0];
	assign ram_we    = (state_q == ST_FINISH) && (cmd_q == CMD_ALLOCATE) && !mod_busy;

	bctd_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (alloc_idx),
		.wdata ({id_q, blk_q}),
		.raddr (cnt_q[IW-1:0]),
		.rdata (rd_word)
	);

	// compare the entry read back
	assign rd_owner  = rd_word[WORD_W-1 -: OWNER_W];
	assign rd_blk    = XW'(rd_word[BLOCK_W-1:0]);
	assign rd_valid  = valid_q[idx_s1];
	assign owner_hit = rd_valid && (rd_owner == id_q) && (id_q != FREE_ID);
	assign match_a   = owner_hit && (rd_blk == bs_q);
	assign match_b   = owner_hit && (rd_blk == be_q);
	assign match_inv = owner_hit && (rd_blk >= bs_q) && (rd_blk <= be_q);
	assign is_free   = !rd_valid || (rd_owner == FREE_ID);

	// sequencer and directory state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_s1        <= 1'b0;
			valid_q      <= '0;
			tick_q       <= '0;
			done_q       <= 1'b0;
			cnt_q        <= '0;
			found_a_q    <= 1'b0;
			found_b_q    <= 1'b0;
			found_free_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			rd_s1  <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					cnt_q        <= '0;
					found_a_q    <= 1'b0;
					found_b_q    <= 1'b0;
					found_free_q <= 1'b0;
					case (cmd_q)
						CMD_LOOKUP: begin
							if (!len_ok || n == '0) begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_SCAN;
							end
						end
						CMD_ALLOCATE: begin
							if (n == '0) begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								tick_q  <= tick_next;
								state_q <= ST_SCAN;
							end
						end
						CMD_INV_RANGE: begin
							if (!len_ok || id_q == FREE_ID || n == '0) begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_SCAN;
							end
						end
						default: begin
							valid_q <= '0;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_SCAN: begin
					if (rd_s1) begin
						if (match_a && !found_a_q) begin
							found_a_q <= 1'b1;
						end
						if (match_b && !found_b_q) begin
							found_b_q <= 1'b1;
						end
						if (is_free && !found_free_q) begin
							found_free_q <= 1'b1;
						end
						if (cmd_q == CMD_INV_RANGE && match_inv) begin
							valid_q[idx_s1] <= 1'b0;
						end
						if (last_s1) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (cmd_q != CMD_ALLOCATE) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (!mod_busy) begin
						valid_q[alloc_idx] <= (id_q != FREE_ID);
						done_q             <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// capture the transaction and scan payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd_t'(command);
			id_q  <= disk_id;
			pos_q <= byte_pos;
			len_q <= byte_len;
			blk_q <= block_number;
			tmr_q <= timer_usec;
		end
		if (state_q == ST_PREP) begin
			bs_q    <= bs_c;
			be_q    <= be_c;
			span2_q <= span2_c;
		end
		idx_s1  <= cnt_q[IW-1:0];
		last_s1 <= (cnt_q == n - CW'(1));
		if (state_q == ST_SCAN && rd_s1) begin
			if (match_a && !found_a_q) begin
				ent_a_q <= idx_s1;
			end
			if (match_b && !found_b_q) begin
				ent_b_q <= idx_s1;
			end
			if (is_free && !found_free_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP || state_q == ST_FINISH) begin
			hit_q        <= 1'b0;
			span_q       <= 2'd0;
			first_q      <= '0;
			second_q     <= '0;
			alloc_ent_q  <= '0;
			alloc_done_q <= 1'b0;
			if (cmd_q == CMD_LOOKUP && state_q == ST_PREP && len_ok) begin
				span_q <= span2_c ? 2'd2 : 2'd1;
			end
			if (cmd_q == CMD_LOOKUP && state_q == ST_FINISH) begin
				span_q <= span2_q ? 2'd2 : 2'd1;
				if (found_a_q && (!span2_q || found_b_q)) begin
					hit_q   <= 1'b1;
					first_q <= to_out(ent_a_q);
					if (span2_q) begin
						second_q <= to_out(ent_b_q);
					end
				end
			end
			if (cmd_q == CMD_ALLOCATE && state_q == ST_FINISH) begin
				alloc_ent_q  <= to_out(alloc_idx);
				alloc_done_q <= 1'b1;
			end
		end
	end

	// configuration register
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eiu_q <= '0;
		end else if (cfg_write && paddr[2] == REG_ENTRIES_IN_USE) begin
			eiu_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_ENTRIES_IN_USE) ? APB_DATA_W'(eiu_q) : '0;
	assign pready = 1'b1;

	// outputs
	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign hit             = hit_q;
	assign span_blocks     = span_q;
	assign first_entry     = first_q;
	assign second_entry    = second_q;
	assign allocated_entry = alloc_ent_q;
	assign allocate_done   = alloc_done_q;

endmodule

// File: test/block_cache_tag_directory_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_cache_tag_directory_test
// Self-checking bench for the cache tag directory. A short directed table
// covers the register extremes, every command, invalid and out-of-range
// spans, the free marker used as a disk id and random replacement. Random
// phases follow, each under its own entries_in_use setting, with small pools
// of disk ids and blocks so that lookups hit and the directory fills up.
// Untyped transactions are checked against a cycle-free model of the directory.
// ----------------------------------------------------------------------------
module block_cache_tag_directory_test;
	import bctd_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int LATENCY_WAIT = ENTRIES_DEF + 12;
	localparam int BLOCK_BYTES  = 1 << BLOCK_SHIFT_DEF;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 150;
	localparam int PLAN_ROWS    = 28;

	localparam logic [APB_ADDR_W-1:0] IN_USE_ADDR = {REG_ENTRIES_IN_USE, 2'b00};

	typedef struct packed {
		cmd_t                 cmd;
		logic [OWNER_W-1:0]   id;
		logic [POS_W-1:0]     pos;
		logic [LEN_W-1:0]     len;
		logic [BLOCK_W-1:0]   blk;
		logic [TIMER_W-1:0]   tmr;
	} tag_req_t;

	typedef struct packed {
		logic                 hit;
		logic [1:0]           span;
		logic [IDX_OUT_W-1:0] first;
		logic [IDX_OUT_W-1:0] second;
		logic [IDX_OUT_W-1:0] alloc;
		logic                 alloc_ok;
	} tag_resp_t;

	typedef struct packed {
		logic      is_cfg;
		logic [7:0] cfg;
		tag_req_t  req;
		logic      typed;
		tag_resp_t want;
	} plan_row_t;

	// DUT signals
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [1:0]            command = '0;
	logic [OWNER_W-1:0]    disk_id = '0;
	logic [POS_W-1:0]      byte_pos = '0;
	logic [LEN_W-1:0]      byte_len = '0;
	logic [BLOCK_W-1:0]    block_number = '0;
	logic [TIMER_W-1:0]    timer_usec = '0;
	logic                  done;
	logic                  hit;
	logic [1:0]            span_blocks;
	logic [IDX_OUT_W-1:0]  first_entry;
	logic [IDX_OUT_W-1:0]  second_entry;
	logic [IDX_OUT_W-1:0]  allocated_entry;
	logic                  allocate_done;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// directory model state
	logic [OWNER_W-1:0] dir_owner [ENTRIES_DEF];
	logic [BLOCK_W-1:0] dir_block [ENTRIES_DEF];
	logic [TICK_W-1:0]  dir_ticks;
	logic [7:0]         dir_in_use;

	tag_resp_t   due_results [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	// random stimulus pools, refreshed per phase
	logic [OWNER_W-1:0] owner_pool [3];
	logic [BLOCK_W-1:0] block_base;
	int unsigned        alloc_weight;
	int unsigned        phase_size [PHASES] = '{1, 128, 2, 0, 3, 127, 255, 16, 1, 64, 128, 5};

	// directed table: config rows among commands; typed rows carry their result
	plan_row_t plan [PLAN_ROWS] = '{
		'{1'b0, 8'd0, '{CMD_LOOKUP, 16'h0000, 32'h0000_0000, 20'd1, 17'd0, 20'd0},
			1'b1, '{1'b0, 2'd1, 7'd0, 7'd0, 7'd0, 1'b0}},
		'{1'b0, 8'd0, '{CMD_ALLOCATE, 16'h0000, 32'h0000_0000, 20'd1, 17'd0, 20'd0},
			1'b1, '0},
		'{1'b0, 8'd0, '{CMD_INV_RANGE, 16'h0000, 32'h0000_0000, 20'd32768, 17'd0, 20'd0},
			1'b1, '0},
		'{1'b0, 8'd0, '{CMD_INV_ALL, 16'h0000, 32'h0000_0000, 20'd0, 17'd0, 20'd0},
			1'b1, '0},
		'{1'b1, 8'd128, '0, 1'b0, '0},
		'{1'b0, 8'd0, '{CMD_ALLOCATE, 16'h0000, 32'h0000_0000, 20'd0, 17'd0, 20'd999999},
			1'b1, '{1'b0, 2'd0, 7'd0, 7'd0, 7'd0, 1'b1}},
		'{1'b0, 8'd0, '{CMD_ALLOCATE, 16'hFFFE, 32'h0000_0000, 20'd0, 17'h1FFFF, 20'd0},
			1'b1, '{1'b0, 2'd0, 7'd0, 7'd0, 7'd1, 1'b1}},
		'{1'b0, 8'd0, '{CMD_ALLOCATE, 16'hFFFF, 32'h0000_0000, 20'd0, 17'd5, 20'd0},
			1'b1, '{1'b0, 2'd0, 7'd0, 7'd0, 7'd2, 1'b1}},
		'{1'b0, 8'd0, '{CMD_ALLOCATE, 16'h0000, 32'h0000_0000, 20'd0, 17'd1, 20'd0},
			1'b1, '{1'b0, 2'd0, 7'd0, 7'd0, 7'd2, 1'b1}},
		'{1'b0, 8'd0, '{CMD_LOOKUP, 16'h0000, 32'h0000_0000, 20'd32768, 17'd0, 20'd0},
			1'b1, '{1'b1, 2'd1, 7'd0, 7'd0, 7'd0, 1'b0}},
		'{1'b0, 8'd0, '{CMD_LOOKUP, 16'h0000, 32'h0000_7FFF, 20'd2, 17'd0, 20'd0},
			1'b1, '{1'b1, 2'd2, 7'd0, 7'd2, 7'd0, 1'b0}},
		'{1'b0, 8'd0, '{CMD_LOOKUP, 16'hFFFE, 32'hFFFF_FFFF, 20'd1, 17'd0, 20'd0},
			1'b1, '{1'b1, 2'd1, 7'd1, 7'd0, 7'd0, 1'b0}},
		'{1'b0, 8'd0, '{CMD_LOOKUP, 16'hFFFE, 32'hFFFF_FFFF, 20'd2, 17'd0, 20'd0},
			1'b1, '{1'b0, 2'd2, 7'd0, 7'd0, 7'd0, 1'b0}},
		'{1'b0, 8'd0, '{CMD_LOOKUP, 16'hFFFF, 32'h0002_8000, 20'd1, 17'd0, 20'd0},
			1'b1, '{1'b0, 2'd1, 7'd0, 7'd0, 7'd0, 1'b0}},
		'{1'b0, 8'd0, '{CMD_LOOKUP, 16'h0000, 32'h0000_0000, 20'd0, 17'd0, 20'd0},
			1'b1, '0},
		'{1'b0, 8'd0, '{CMD_LOOKUP, 16'h0000, 32'h0000_0000, 20'd32769, 17'd0, 20'd0},
			1'b1, '0},
		'{1'b0, 8'd0, '{CMD_LOOKUP, 16'h0000, 32'h0000_0000, 20'hFFFFF, 17'd0, 20'd0},
			1'b1, '0},
		'{1'b0, 8'd0, '{CMD_INV_RANGE, 16'h0000, 32'h0000_0000, 20'd0, 17'd0, 20'd0},
			1'b1, '0},
		'{1'b0, 8'd0, '{CMD_INV_RANGE, 16'hFFFF, 32'h0000_0000, 20'd32768, 17'd0, 20'd0},
			1'b1, '0},
		'{1'b0, 8'd0, '{CMD_INV_RANGE, 16'h0000, 32'h0000_7FFF, 20'd2, 17'd0, 20'd0},
			1'b1, '0},
		'{1'b0, 8'd0, '{CMD_LOOKUP, 16'h0000, 32'h0000_7FFF, 20'd2, 17'd0, 20'd0},
			1'b0, '0},
		'{1'b1, 8'd3, '0, 1'b0, '0},
		'{1'b0, 8'd0, '{CMD_ALLOCATE, 16'h0007, 32'h0000_0000, 20'd0, 17'd9, 20'd0},
			1'b0, '0},
		'{1'b0, 8'd0, '{CMD_ALLOCATE, 16'h0007, 32'h0000_0000, 20'd0, 17'd10, 20'd0},
			1'b0, '0},
		'{1'b0, 8'd0, '{CMD_ALLOCATE, 16'h0007, 32'h0000_0000, 20'd0, 17'd11, 20'd999999},
			1'b0, '0},
		'{1'b0, 8'd0, '{CMD_LOOKUP, 16'h0007, 32'h0005_8000, 20'd1, 17'd0, 20'd0},
			1'b0, '0},
		'{1'b1, 8'd255, '0, 1'b0, '0},
		'{1'b0, 8'd0, '{CMD_INV_ALL, 16'h0007, 32'h0000_0000, 20'd0, 17'd0, 20'd0},
			1'b1, '0}
	};

	block_cache_tag_directory DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.disk_id        (disk_id),
		.byte_pos       (byte_pos),
		.byte_len       (byte_len),
		.block_number   (block_number),
		.timer_usec     (timer_usec),
		.done           (done),
		.hit            (hit),
		.span_blocks    (span_blocks),
		.first_entry    (first_entry),
		.second_entry   (second_entry),
		.allocated_entry(allocated_entry),
		.allocate_done  (allocate_done),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[block_cache_tag_directory] ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// lowest active entry that holds this disk's block, or -1
	function automatic int find_tag(input logic [OWNER_W-1:0] id,
			input longint unsigned blk, input int unsigned n);
		if (id == FREE_ID)
			return -1;
		for (int unsigned i = 0; i < n; i++)
			if (dir_owner[i] == id && 64'(dir_block[i]) == blk)
				return int'(i);
		return -1;
	endfunction

	// apply one command to the directory model and return its result
	function automatic tag_resp_t directory_predict(input tag_req_t r);
		tag_resp_t         res;
		int unsigned       n;
		int unsigned       span;
		int unsigned       pick;
		longint unsigned   first_blk;
		longint unsigned   last_blk;
		int                a;
		int                b;
		bit                found;
		res = '0;
		n = (dir_in_use > ENTRIES_DEF) ? ENTRIES_DEF : dir_in_use;
		span = 0;
		first_blk = 0;
		last_blk = 0;
		if (r.len != 0 && r.len <= BLOCK_BYTES) begin
			first_blk = 64'(r.pos) >> BLOCK_SHIFT_DEF;
			last_blk = (64'(r.pos) + 64'(r.len) - 64'd1) >> BLOCK_SHIFT_DEF;
			span = int'(last_blk - first_blk) + 1;
		end
		case (r.cmd)
			CMD_LOOKUP: begin
				res.span = span[1:0];
				if (span != 0 && n != 0) begin
					a = find_tag(r.id, first_blk, n);
					b = (span == 2) ? find_tag(r.id, last_blk, n) : 0;
					if (a >= 0 && b >= 0) begin
						res.hit = 1'b1;
						res.first = a[IDX_OUT_W-1:0];
						res.second = (span == 2) ? b[IDX_OUT_W-1:0] : '0;
					end
				end
			end
			CMD_ALLOCATE: begin
				if (n != 0) begin
					dir_ticks = dir_ticks + 1'b1;
					found = 1'b0;
					pick = 0;
					for (int unsigned i = 0; i < n; i++) begin
						if (!found && dir_owner[i] == FREE_ID) begin
							pick = i;
							found = 1'b1;
						end
					end
					// no free entry: mix ticks and coarse timer bits
					if (!found)
						pick = ((int'(dir_ticks) + int'(r.tmr >> TIMER_LSB)) & 255) % n;
					dir_owner[pick] = r.id;
					dir_block[pick] = r.blk;
					res.alloc = pick[IDX_OUT_W-1:0];
					res.alloc_ok = 1'b1;
				end
			end
			CMD_INV_RANGE: begin
				if (span != 0 && r.id != FREE_ID)
					for (int unsigned i = 0; i < n; i++)
						if (dir_owner[i] == r.id && 64'(dir_block[i]) >= first_blk &&
								64'(dir_block[i]) <= last_blk)
							dir_owner[i] = FREE_ID;
			end
			default: begin
				for (int i = 0; i < ENTRIES_DEF; i++)
					dir_owner[i] = FREE_ID;
			end
		endcase
		return res;
	endfunction

	// draw one random command around the current pools
	function automatic tag_req_t draw_request();
		tag_req_t                   r;
		int unsigned                roll;
		logic [BLOCK_W-1:0]         blkno;
		logic [BLOCK_SHIFT_DEF-1:0] offset;
		roll = $urandom_range(0, 199);
		if (roll == 0)
			r.cmd = CMD_INV_ALL;
		else if (roll < 1 + alloc_weight)
			r.cmd = CMD_ALLOCATE;
		else if (roll < 31 + alloc_weight)
			r.cmd = CMD_INV_RANGE;
		else
			r.cmd = CMD_LOOKUP;
		if ($urandom_range(0, 9) != 0)
			r.id = owner_pool[$urandom_range(0, 2)];
		else
			r.id = OWNER_W'($urandom);
		blkno = block_base + BLOCK_W'($urandom_range(0, 7));
		offset = BLOCK_SHIFT_DEF'($urandom);
		r.pos = {blkno, offset};
		r.blk = ($urandom_range(0, 3) != 0) ? blkno : BLOCK_W'($urandom);
		r.tmr = TIMER_W'($urandom_range(0, 999999));
		case ($urandom_range(0, 9))
			0: r.len = '0;
			1: r.len = LEN_W'($urandom_range(BLOCK_BYTES + 1, (1 << LEN_W) - 1));
			2: r.len = LEN_W'(BLOCK_BYTES) - LEN_W'(offset);
			3: r.len = LEN_W'(BLOCK_BYTES);
			4: r.len = LEN_W'($urandom_range(1, 4));
			default: r.len = LEN_W'($urandom_range(1, BLOCK_BYTES));
		endcase
		// occasional position anywhere in the address space
		if ($urandom_range(0, 19) == 0)
			r.pos = $urandom;
		return r;
	endfunction

	// present one command, hold until taken, then queue its result
	task automatic issue_command(input tag_req_t r, input int unsigned gap,
			input bit typed, input tag_resp_t typed_want);
		tag_resp_t predicted;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= r.cmd;
		disk_id <= r.id;
		byte_pos <= r.pos;
		byte_len <= r.len;
		block_number <= r.blk;
		timer_usec <= r.tmr;
		do @(posedge clk); while (busy);
		predicted = directory_predict(r);
		due_results.push_back(typed ? typed_want : predicted);
	endtask

	// wait for every outstanding result, then idle for the extra cycles given
	task automatic wait_settled(input int unsigned extra);
		while (due_results.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// write entries_in_use, then read it back on the same select
	task automatic set_entries_in_use(input logic [7:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= IN_USE_ADDR;
		pwdata <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		dir_in_use = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== APB_DATA_W'(value))
			report_mismatch($sformatf("entries_in_use reads %h, wrote %h", prdata, value));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		tag_resp_t got;
		tag_resp_t want;
		if (arst_n && done) begin
			got = {hit, span_blocks, first_entry, second_entry, allocated_entry,
				allocate_done};
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result %h with no command pending", got));
			end else begin
				want = due_results.pop_front();
				if (got !== want)
					report_mismatch($sformatf(
						"hit %0d/%0d span %0d/%0d first %0d/%0d second %0d/%0d alloc %0d/%0d ok %0d/%0d",
						got.hit, want.hit, got.span, want.span, got.first, want.first,
						got.second, want.second, got.alloc, want.alloc,
						got.alloc_ok, want.alloc_ok));
			end
		end
	end

	initial begin : stimulus
		bit          burst;
		logic [7:0]  size;
		for (int i = 0; i < ENTRIES_DEF; i++) begin
			dir_owner[i] = FREE_ID;
			dir_block[i] = '0;
		end
		dir_ticks = '0;
		dir_in_use = '0;
		burst = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				start <= 1'b0;
				wait_settled(4);
				set_entries_in_use(plan[i].cfg);
			end else begin
				issue_command(plan[i].req, $urandom_range(0, 19), plan[i].typed,
					plan[i].want);
			end
		end

		// random phases, directory state carried across them
		for (int p = 0; p < PHASES; p++) begin
			start <= 1'b0;
			wait_settled(4);
			size = (p == PHASES - 1) ? 8'($urandom_range(0, 255)) : 8'(phase_size[p]);
			owner_pool[0] = OWNER_W'($urandom);
			owner_pool[1] = OWNER_W'($urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0: owner_pool[2] = FREE_ID;
				1: owner_pool[2] = FREE_ID - 1'b1;
				2: owner_pool[2] = '0;
				default: owner_pool[2] = OWNER_W'($urandom);
			endcase
			block_base = ($urandom_range(0, 3) == 0) ? {BLOCK_W{1'b1}} - BLOCK_W'(3) :
				BLOCK_W'($urandom);
			alloc_weight = $urandom_range(50, 140);
			set_entries_in_use(size);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 29) == 0)
					burst = !burst;
				issue_command(draw_request(), burst ? 0 : $urandom_range(0, 19), 1'b0, '0);
			end
		end

		// drain and finish
		start <= 1'b0;
		wait_settled(LATENCY_WAIT);
		if (mismatch_count == 0)
			$display("[block_cache_tag_directory] OK");
		else
			$display("[block_cache_tag_directory] ERROR");
		$finish;
	end

endmodule
